// ----- rtl/u8v_pkg.sv -----
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and byte-class constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] CONT_MASK      = 8'hC0;
    localparam logic [7:0] CONT_CODE      = 8'h80;
    localparam logic [7:0] ASCII_LIMIT    = 8'h80;
    localparam logic [7:0] LEAD2_MASK     = 8'hE0;
    localparam logic [7:0] LEAD2_CODE     = 8'hC0;
    localparam logic [7:0] LEAD2_MIN      = 8'hC2;
    localparam logic [7:0] LEAD3_MASK     = 8'hF0;
    localparam logic [7:0] LEAD3_CODE     = 8'hE0;
    localparam logic [7:0] LEAD4_MASK     = 8'hF8;
    localparam logic [7:0] LEAD4_CODE     = 8'hF0;
    localparam logic [7:0] LEAD4_MAX      = 8'hF4;

    localparam logic [1:0] OWED_NONE      = 2'd0;
    localparam logic [1:0] OWED_ONE       = 2'd1;
    localparam logic [1:0] OWED_TWO       = 2'd2;
    localparam logic [1:0] OWED_THREE     = 2'd3;

    typedef struct packed {
        logic [1:0] owed;
        logic       err;
    } t_state;

    typedef struct packed {
        logic emit;
        logic verdict;
    } t_result;

endpackage

// ----- rtl/utf8_stream_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks zero-terminated byte strings against the UTF-8 lead/continuation
// grammar and returns one verdict per string.
// ----------------------------------------------------------------------------
// One byte is taken per beat, every cycle while the output register is free or
// draining. Non-zero bytes only update the owed-continuation count and the
// sticky error flag; a zero byte ends the string and loads a verdict into the
// output register, with the state cleared for the next string. The validator
// takes one byte per cycle; the input stalls only while a verdict waits in the
// output register.
// ----------------------------------------------------------------------------
module utf8_stream_validator
    import u8v_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_string_valid
);

    t_state  r_state;
    t_state  n_state;
    t_result w_result;
    logic    r_valid;
    logic    r_verdict;
    logic    w_accept;

    u8v_step u_step (
        .i_data_byte (i_data_byte),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (w_result)
    );

    assign o_stall        = r_valid && i_stall;
    assign w_accept       = i_valid && !o_stall;
    assign o_valid        = r_valid;
    assign o_string_valid = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_accept && w_result.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_result.emit) begin
            r_verdict <= w_result.verdict;
        end
    end

    a_err_no_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err |-> (r_state.owed == OWED_NONE))
        else $error("error flag set with continuations owed");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data_byte == BYTE_END) |=>
            (r_valid && r_state.owed == OWED_NONE && !r_state.err))
        else $error("end byte did not post verdict and clear state");

    a_hold_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_verdict)))
        else $error("stalled verdict lost or changed");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !w_accept)
        else $error("byte accepted while verdict blocked");

endmodule

// ----- rtl/u8v_step.sv -----
// ----------------------------------------------------------------------------
// u8v_step
// Next-state and verdict logic for one byte of the UTF-8 grammar check.
// ----------------------------------------------------------------------------
module u8v_step
    import u8v_pkg::*;
(
    input  logic [7:0] i_data_byte,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    always_comb begin
        o_state          = i_state;
        o_result.emit    = 1'b0;
        o_result.verdict = 1'b0;
        if (i_data_byte == BYTE_END) begin
            o_result.emit    = 1'b1;
            o_result.verdict = !i_state.err && (i_state.owed == OWED_NONE);
            o_state.owed     = OWED_NONE;
            o_state.err      = 1'b0;
        end else if (i_state.err) begin
            o_state = i_state;
        end else if (i_state.owed != OWED_NONE) begin
            if ((i_data_byte & CONT_MASK) == CONT_CODE) begin
                o_state.owed = i_state.owed - 2'd1;
            end else begin
                o_state.err  = 1'b1;
                o_state.owed = OWED_NONE;
            end
        end else if (i_data_byte < ASCII_LIMIT) begin
            o_state = i_state;
        end else if ((i_data_byte & LEAD2_MASK) == LEAD2_CODE) begin
            if (i_data_byte < LEAD2_MIN) begin
                o_state.err = 1'b1;
            end else begin
                o_state.owed = OWED_ONE;
            end
        end else if ((i_data_byte & LEAD3_MASK) == LEAD3_CODE) begin
            o_state.owed = OWED_TWO;
        end else if ((i_data_byte & LEAD4_MASK) == LEAD4_CODE) begin
            if (i_data_byte > LEAD4_MAX) begin
                o_state.err = 1'b1;
            end else begin
                o_state.owed = OWED_THREE;
            end
        end else begin
            o_state.err = 1'b1;
        end
    end

endmodule
